/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL. Compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising clock edge while out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Check that cond never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* rtl/imubac_pkg.sv */
// ----------------------------------------------------------------------------
// imubac_pkg
// Types, widths and helpers shared by the IMU bias calibrator blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imubac_pkg;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned GRAV_W = 15;
  localparam int unsigned NLANE  = 3;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd4096;

  localparam logic OP_CORRECT = 1'b0;
  localparam logic OP_CAL     = 1'b1;
  localparam logic SN_ACCEL   = 1'b0;
  localparam logic SN_GYRO    = 1'b1;

  // Control of one beat, used both at load into stage 1 and at commit.
  typedef struct packed {
    logic load;
    logic cal;
    logic sensor;
    logic arm;
    logic done;
  } imubac_ctl_t;

  // Per-lane result handed to the merge stage.
  typedef struct packed {
    logic signed [SMP_W-1:0] corr;
    logic [1:0]              off_zero;  // next offset is zero, per sensor
  } imubac_lane_t;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [24:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/imubac_in_if.sv */
// ----------------------------------------------------------------------------
// imubac_in_if
// Input channel: one sample or calibration beat per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imubac_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               sensor;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, opcode, sensor, sample_x, sample_y, sample_z,
                  input ready);
  modport sink   (input valid, opcode, sensor, sample_x, sample_y, sample_z,
                  output ready);
endinterface

/* rtl/imubac_out_if.sv */
// ----------------------------------------------------------------------------
// imubac_out_if
// Result channel: corrected sample and calibration status per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imubac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               cal_done;
  logic               have_calibration;

  modport source (output valid, out_x, out_y, out_z, cal_done, have_calibration,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, cal_done, have_calibration,
                  output ready);
endinterface

/* rtl/imubac_lane.sv */
// ----------------------------------------------------------------------------
// imubac_lane
// One axis: run sums, offsets, constant-reciprocal average and correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imubac_lane #(
  parameter int unsigned RUN_LENGTH = 100
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  imubac_pkg::imubac_ctl_t                ld_i,
  input  imubac_pkg::imubac_ctl_t                cm_i,
  input  logic signed [imubac_pkg::SMP_W-1:0]    sample_i,
  input  logic [imubac_pkg::GRAV_W-1:0]          grav_i,
  output imubac_pkg::imubac_lane_t               stat_o
);

  localparam int unsigned SUM_W = imubac_pkg::SUM_W;
  localparam int unsigned SMP_W = imubac_pkg::SMP_W;
  localparam int unsigned SHIFT = 31;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << SHIFT) + 64'(RUN_LENGTH) - 64'd1) / 64'(RUN_LENGTH));

  logic signed [SUM_W-1:0] sum_q [2];
  logic signed [SUM_W-1:0] sum_d [2];
  logic signed [SMP_W-1:0] off_q [2];
  logic signed [SMP_W-1:0] off_d [2];
  logic signed [SUM_W-1:0] val_q;
  logic signed [SUM_W-1:0] val_d;
  logic signed [SUM_W-1:0] acc;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W+31:0]       prod;
  logic [SUM_W-1:0]        quo;
  logic signed [24:0]      avg;
  logic signed [SMP_W:0]   diff;

  // Stage 1: accumulate on accept
  always_comb begin
    acc = sum_q[ld_i.sensor] + SUM_W'(sample_i)
        + ((ld_i.sensor == imubac_pkg::SN_ACCEL) ? SUM_W'(grav_i) : '0);
    sum_d = sum_q;
    val_d = val_q;
    if (ld_i.load) begin
      if (ld_i.cal == imubac_pkg::OP_CAL) begin
        if (ld_i.arm) begin
          sum_d[ld_i.sensor] = '0;
        end else begin
          sum_d[ld_i.sensor] = acc;
        end
        val_d = acc;
      end else begin
        val_d = SUM_W'(sample_i);
      end
    end
  end

  // Stage 2: divide by the run length, round toward zero
  always_comb begin
    neg  = val_q[SUM_W-1];
    mag  = neg ? SUM_W'(-val_q) : SUM_W'(val_q);
    prod = (SUM_W+32)'(mag) * (SUM_W+32)'(RECIP);
    quo  = prod[SHIFT +: SUM_W];
    avg  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    diff = (SMP_W+1)'($signed(val_q[SMP_W-1:0])) - (SMP_W+1)'(off_q[cm_i.sensor]);
    off_d = off_q;
    if (cm_i.load && cm_i.cal == imubac_pkg::OP_CAL) begin
      if (cm_i.arm) begin
        off_d[cm_i.sensor] = '0;
      end else if (cm_i.done) begin
        off_d[cm_i.sensor] = imubac_pkg::sat16(avg);
      end
    end
  end

  assign stat_o.corr     = imubac_pkg::sat16(25'(diff));
  assign stat_o.off_zero = {off_d[1] == '0, off_d[0] == '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
    end else begin
      sum_q <= sum_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* rtl/imubac_ctrl.sv */
// ----------------------------------------------------------------------------
// imubac_ctrl
// Run counters per sensor, gravity register and stage-1 pipeline control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imubac_ctrl #(
  parameter int unsigned RUN_LENGTH = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              opcode_i,
  input  logic                              sensor_i,
  output logic                              in_ready_o,
  input  logic                              adv_i,
  input  logic                              cfg_we_i,
  input  logic [imubac_pkg::GRAV_W-1:0]     cfg_wdata_i,
  output logic [imubac_pkg::GRAV_W-1:0]     grav_o,
  output imubac_pkg::imubac_ctl_t           ld_o,
  output imubac_pkg::imubac_ctl_t           cm_o
);

  localparam int unsigned CNT_W = $clog2(RUN_LENGTH + 1);

  logic [CNT_W-1:0]            cnt_q [2];
  logic [CNT_W-1:0]            cnt_d [2];
  logic [1:0]                  armed_q, armed_d;
  logic [CNT_W:0]              cnt_nx;
  logic                        s1_vld_q, s1_vld_d;
  imubac_pkg::imubac_ctl_t     s1_q, s1_d;
  logic [imubac_pkg::GRAV_W-1:0] grav_q;
  logic                        acc;

  assign in_ready_o = !s1_vld_q || adv_i;
  assign acc        = in_valid_i && in_ready_o;
  assign grav_o     = grav_q;
  assign cnt_nx     = (CNT_W+1)'(cnt_q[sensor_i]) + (CNT_W+1)'(1);

  always_comb begin
    ld_o.load   = acc;
    ld_o.cal    = opcode_i;
    ld_o.sensor = sensor_i;
    ld_o.arm    = (opcode_i == imubac_pkg::OP_CAL) && !armed_q[sensor_i];
    ld_o.done   = (opcode_i == imubac_pkg::OP_CAL) && armed_q[sensor_i]
               && (cnt_nx >= (CNT_W+1)'(RUN_LENGTH));

    cnt_d   = cnt_q;
    armed_d = armed_q;
    if (acc && opcode_i == imubac_pkg::OP_CAL) begin
      if (ld_o.arm) begin
        armed_d[sensor_i] = 1'b1;
        cnt_d[sensor_i]   = '0;
      end else if (ld_o.done) begin
        armed_d[sensor_i] = 1'b0;
        cnt_d[sensor_i]   = '0;
      end else begin
        cnt_d[sensor_i]   = cnt_nx[CNT_W-1:0];
      end
    end

    // Hold stage 1 while the output side stalls
    s1_vld_d = s1_vld_q;
    s1_d     = s1_q;
    if (in_ready_o) begin
      s1_vld_d = in_valid_i;
      s1_d     = ld_o;
    end

    cm_o      = s1_q;
    cm_o.load = s1_vld_q && adv_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      armed_q  <= '0;
      s1_vld_q <= 1'b0;
      grav_q   <= imubac_pkg::GRAV_RESET;
    end else begin
      cnt_q    <= cnt_d;
      armed_q  <= armed_d;
      s1_vld_q <= s1_vld_d;
      if (cfg_we_i) begin
        grav_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  `ASSERT_PROP(a_cnt0_below_len, clk_i, rst_ni, cnt_q[0] < CNT_W'(RUN_LENGTH))
  `ASSERT_PROP(a_cnt1_below_len, clk_i, rst_ni, cnt_q[1] < CNT_W'(RUN_LENGTH))
  `ASSERT_PROP(a_done_disarms, clk_i, rst_ni, ld_o.load && ld_o.done |=> !armed_q[$past(sensor_i)])
  `ASSERT_NEVER(a_stall_without_item, clk_i, rst_ni, !in_ready_o && !s1_vld_q)
  `ASSERT_PROP(a_s1_holds, clk_i, rst_ni, s1_vld_q && !adv_i |=> s1_vld_q && $stable(s1_q))

endmodule

/* rtl/imubac_merge.sv */
// ----------------------------------------------------------------------------
// imubac_merge
// Combines lane results, keeps the calibrated flag, drives the output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imubac_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  imubac_pkg::imubac_ctl_t               cm_i,
  input  imubac_pkg::imubac_lane_t              lane_i [imubac_pkg::NLANE],
  output logic                                  adv_o,
  imubac_out_if.source                          out_o
);

  logic                          vld_q, vld_d;
  logic                          flag_q, flag_d;
  logic signed [15:0]            x_q, y_q, z_q;
  logic                          done_q, hc_q;
  logic                          acc_zero, gyr_zero;

  assign adv_o = !vld_q || out_o.ready;

  always_comb begin
    acc_zero = lane_i[0].off_zero[0] && lane_i[1].off_zero[0] && lane_i[2].off_zero[0];
    gyr_zero = lane_i[0].off_zero[1] && lane_i[1].off_zero[1] && lane_i[2].off_zero[1];
    flag_d   = flag_q;
    if (cm_i.load && cm_i.done) begin
      flag_d = !acc_zero && !gyr_zero;
    end
    vld_d = vld_q;
    if (adv_o) begin
      vld_d = cm_i.load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_i.load) begin
      if (cm_i.cal == imubac_pkg::OP_CAL) begin
        x_q <= '0;
        y_q <= '0;
        z_q <= '0;
      end else begin
        x_q <= lane_i[0].corr;
        y_q <= lane_i[1].corr;
        z_q <= lane_i[2].corr;
      end
      done_q <= cm_i.done;
      hc_q   <= flag_d;
    end
  end

  assign out_o.valid            = vld_q;
  assign out_o.out_x            = x_q;
  assign out_o.out_y            = y_q;
  assign out_o.out_z            = z_q;
  assign out_o.cal_done         = done_q;
  assign out_o.have_calibration = hc_q;

endmodule

/* rtl/imu_bias_average_and_correct_top.sv */
// ----------------------------------------------------------------------------
// imu_bias_average_and_correct_top
// Three-axis accel/gyro bias calibration by averaging, and bias correction.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_i      in    valid / ready    opcode, sensor, sample_x/y/z
//  out_o     out   valid / ready    out_x/y/z, cal_done, have_calibration
//  cfg       in    cfg_we_i         cfg_wdata_i = gravity_counts (15 bit)
//
//  One beat per cycle unless out_o stalls; stage 1 and output are registered.
//  Stage 1 adds into the run sums, stage 2 averages with a 24x32 reciprocal
//  multiply in each axis lane and forms the corrected sample.
//  Reset clears sums, offsets, run counters and flag; no clearing pass.
//  A stall on out_o holds both stages; in_i keeps taking beats while a stage
//  is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_bias_average_and_correct_top #(
  parameter int unsigned RUN_LENGTH = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  imubac_in_if.sink                     in_i,
  imubac_out_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [imubac_pkg::GRAV_W-1:0] cfg_wdata_i
);

  imubac_pkg::imubac_ctl_t       ld, cm;
  imubac_pkg::imubac_lane_t      lane_stat [imubac_pkg::NLANE];
  logic [imubac_pkg::GRAV_W-1:0] grav;
  logic                          adv;

  imubac_ctrl #(.RUN_LENGTH(RUN_LENGTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .sensor_i    (in_i.sensor),
    .in_ready_o  (in_i.ready),
    .adv_i       (adv),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .grav_o      (grav),
    .ld_o        (ld),
    .cm_o        (cm)
  );

  // Gravity only goes into the z lane
  imubac_lane #(.RUN_LENGTH(RUN_LENGTH)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .cm_i     (cm),
    .sample_i (in_i.sample_x),
    .grav_i   ('0),
    .stat_o   (lane_stat[0])
  );

  imubac_lane #(.RUN_LENGTH(RUN_LENGTH)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .cm_i     (cm),
    .sample_i (in_i.sample_y),
    .grav_i   ('0),
    .stat_o   (lane_stat[1])
  );

  imubac_lane #(.RUN_LENGTH(RUN_LENGTH)) u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .cm_i     (cm),
    .sample_i (in_i.sample_z),
    .grav_i   (grav),
    .stat_o   (lane_stat[2])
  );

  imubac_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cm_i   (cm),
    .lane_i (lane_stat),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule
